### rtl/multi_turn_encoder_tracker_defines.svh
// assertion macros for the multi-turn encoder tracker checker
// no dependencies; included by files that hold concurrent assertions
`ifndef MULTI_TURN_ENCODER_TRACKER_DEFINES_SVH
`define MULTI_TURN_ENCODER_TRACKER_DEFINES_SVH

// generic clocked assertion with an explicit clock and active-low reset
`define MTET_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the default clock and reset names
`define MTET_ASSERT(label, prop, msg) \
  `MTET_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/mtet_pkg.sv
// shared types and constants of the multi-turn encoder tracker
// no dependencies; imported by controller, datapath, top level and checker
`timescale 1ns / 1ps

package mtet_pkg;

  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned TOT_BITS     = 48;
  localparam int unsigned CPT_BITS     = 17;
  localparam int unsigned TURN_BITS    = 32;
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned DIV_CNT_BITS = $clog2(TOT_BITS);

  localparam int unsigned IN_DATA_BITS  = 64;
  localparam int unsigned OUT_DATA_BITS = 96;
  localparam int unsigned OUT_USER_BITS = 2;

  localparam logic [CPT_BITS-1:0] CPT_RESET = CPT_BITS'(8192);
  localparam logic [CPT_BITS-1:0] CPT_MIN   = CPT_BITS'(2);
  localparam logic [CPT_BITS-1:0] CPT_MAX   = CPT_BITS'(65536);

  typedef enum logic [0:0] {
    CMD_UPDATE   = 1'b0,
    CMD_RELOCATE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TURN,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic turn_step;
    logic mul_step;
    logic sum_step;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } ctrl_sts_t;

endpackage

### rtl/mtet_ctrl.sv
// sequencing state machine of the multi-turn encoder tracker
// depends on mtet_pkg; drives the datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module mtet_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mtet_pkg::ctrl_cmd_t cmd_o,
  input  mtet_pkg::ctrl_sts_t sts_i
);
  import mtet_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_TURN;
        end
      end
      ST_TURN: begin
        cmd_o.turn_step = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/mtet_datapath.sv
// tracker state, multiplier, saturating adder and serial modulo unit
// depends on mtet_pkg; steered by mtet_ctrl through ctrl_cmd_t
`timescale 1ns / 1ps

module mtet_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mtet_pkg::CPT_BITS-1:0]         cfg_wdata_i,
  input  logic                                  in_cmd_i,
  input  logic [mtet_pkg::POS_BITS-1:0]         in_raw_i,
  input  logic signed [mtet_pkg::TOT_BITS-1:0]  in_target_i,
  input  mtet_pkg::ctrl_cmd_t                   cmd_i,
  output mtet_pkg::ctrl_sts_t                   sts_o,
  output logic signed [mtet_pkg::TOT_BITS-1:0]  out_total_o,
  output logic [mtet_pkg::ANGLE_BITS-1:0]       out_angle_o,
  output logic signed [mtet_pkg::TURN_BITS-1:0] out_turns_o,
  output logic                                  out_init_o,
  output logic                                  out_sat_o
);
  import mtet_pkg::*;

  localparam int unsigned PROD_W = TURN_BITS + CPT_BITS + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DIFF_W = POS_BITS + 1;

  localparam logic signed [SUM_W-1:0] SUM_TOT_MAX =
    {{(SUM_W-TOT_BITS+1){1'b0}}, {(TOT_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_TOT_MIN = ~SUM_TOT_MAX;
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  // config and captured beat
  logic [CPT_BITS-1:0]        cpt_q;
  logic [CPT_BITS-1:0]        eff_q, eff_d;
  cmd_e                       cmd_q;
  logic [POS_BITS-1:0]        raw_q;
  logic signed [TOT_BITS-1:0] target_q;

  // tracker state
  logic                        init_q;
  logic [POS_BITS-1:0]         start_q;
  logic [POS_BITS-1:0]         last_q;
  logic signed [TURN_BITS-1:0] turns_q;
  logic signed [TOT_BITS-1:0]  offset_q;
  logic                        first_q;

  // arithmetic pipeline
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [TOT_BITS-1:0] total_q, total_d;
  logic                       sat_q, sat_d;
  logic                       neg_q;
  logic [TOT_BITS-1:0]        dvd_q;
  logic [CPT_BITS-1:0]        rem_q, rem_d;
  logic [DIV_CNT_BITS-1:0]    cnt_q;

  // output register
  logic signed [TOT_BITS-1:0]  out_total_q;
  logic [ANGLE_BITS-1:0]       out_angle_q;
  logic signed [TURN_BITS-1:0] out_turns_q;
  logic                        out_init_q;
  logic                        out_sat_q;

  // combinational helpers
  logic signed [DIFF_W-1:0]   step_d;
  logic signed [DIFF_W+1:0]   step2;
  logic signed [DIFF_W+1:0]   cpt_s;
  logic                       wrap_dn, wrap_up;
  logic signed [CPT_BITS:0]   eff_s;
  logic signed [SUM_W-1:0]    base_s, sum_s, clamp_s;
  logic                       clamp_hit;
  logic [CPT_BITS:0]          trial;
  logic [CPT_BITS-1:0]        angle_full;

  always_comb begin
    if (cpt_q < CPT_MIN) begin
      eff_d = CPT_MIN;
    end else if (cpt_q > CPT_MAX) begin
      eff_d = CPT_MAX;
    end else begin
      eff_d = cpt_q;
    end
  end

  // wrap detection on twice the step
  assign step_d  = $signed({1'b0, raw_q}) - $signed({1'b0, last_q});
  assign step2   = (DIFF_W+2)'(step_d) <<< 1;
  assign cpt_s   = $signed({2'b00, eff_q});
  assign wrap_dn = step2 > cpt_s;
  assign wrap_up = step2 < -cpt_s;

  assign eff_s  = $signed({1'b0, eff_q});
  assign prod_d = PROD_W'(turns_q) * PROD_W'(eff_s);

  always_comb begin
    base_s = SUM_W'(prod_q) + SUM_W'(diff_q);
    if (cmd_q == CMD_RELOCATE) begin
      sum_s = SUM_W'(target_q) - base_s;
    end else begin
      sum_s = base_s + SUM_W'(offset_q);
    end
    clamp_hit = 1'b0;
    clamp_s   = sum_s;
    if (sum_s > SUM_TOT_MAX) begin
      clamp_s   = SUM_TOT_MAX;
      clamp_hit = 1'b1;
    end else if (sum_s < SUM_TOT_MIN) begin
      clamp_s   = SUM_TOT_MIN;
      clamp_hit = 1'b1;
    end
    if (cmd_q == CMD_RELOCATE) begin
      total_d = target_q;
      sat_d   = clamp_hit;
    end else if (first_q) begin
      total_d = offset_q;
      sat_d   = 1'b0;
    end else begin
      total_d = clamp_s[TOT_BITS-1:0];
      sat_d   = clamp_hit;
    end
  end

  // restoring division, one quotient bit per cycle, remainder only
  always_comb begin
    trial = {rem_q, dvd_q[TOT_BITS-1]};
    if (trial >= {1'b0, eff_q}) begin
      rem_d = CPT_BITS'(trial - {1'b0, eff_q});
    end else begin
      rem_d = trial[CPT_BITS-1:0];
    end
  end

  // floor modulo from magnitude remainder
  assign angle_full = (neg_q && (rem_q != '0)) ? (eff_q - rem_q) : rem_q;

  assign sts_o.div_last = (cnt_q == DIV_CNT_BITS'(TOT_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpt_q      <= CPT_RESET;
      init_q     <= 1'b0;
      start_q    <= '0;
      last_q     <= '0;
      turns_q    <= '0;
      offset_q   <= '0;
      out_init_q <= 1'b0;
      out_sat_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cpt_q <= cfg_wdata_i;
      end
      if (cmd_i.turn_step && (cmd_q == CMD_UPDATE)) begin
        last_q <= raw_q;
        if (!init_q) begin
          start_q <= raw_q;
          turns_q <= '0;
          init_q  <= 1'b1;
        end else if (wrap_dn) begin
          if (turns_q != TURN_MIN) begin
            turns_q <= turns_q - TURN_BITS'(1);
          end
        end else if (wrap_up) begin
          if (turns_q != TURN_MAX) begin
            turns_q <= turns_q + TURN_BITS'(1);
          end
        end
      end
      if (cmd_i.sum_step && (cmd_q == CMD_RELOCATE)) begin
        offset_q <= clamp_s[TOT_BITS-1:0];
      end
      if (cmd_i.load_out) begin
        out_init_q <= init_q;
        out_sat_q  <= sat_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      eff_q    <= eff_d;
      cmd_q    <= cmd_e'(in_cmd_i);
      raw_q    <= in_raw_i;
      target_q <= in_target_i;
    end
    if (cmd_i.turn_step) begin
      first_q <= (cmd_q == CMD_UPDATE) && !init_q;
    end
    if (cmd_i.mul_step) begin
      prod_q <= prod_d;
      diff_q <= $signed({1'b0, last_q}) - $signed({1'b0, start_q});
    end
    if (cmd_i.sum_step) begin
      total_q <= total_d;
      sat_q   <= sat_d;
      neg_q   <= total_d[TOT_BITS-1];
      dvd_q   <= total_d[TOT_BITS-1] ? TOT_BITS'(-total_d) : TOT_BITS'(total_d);
      rem_q   <= '0;
      cnt_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q + DIV_CNT_BITS'(1);
    end
    if (cmd_i.load_out) begin
      out_total_q <= total_q;
      out_angle_q <= angle_full[ANGLE_BITS-1:0];
      out_turns_q <= turns_q;
    end
  end

  assign out_total_o = out_total_q;
  assign out_angle_o = out_angle_q;
  assign out_turns_o = out_turns_q;
  assign out_init_o  = out_init_q;
  assign out_sat_o   = out_sat_q;

endmodule

### rtl/multi_turn_encoder_tracker.sv
// multi-turn encoder tracker: each input beat passes turn update, multiply,
// saturating add, one bit-serial modulo step per dividend bit and output load
// a new beat is taken only once the last result has gone to the output register
// reset clears tracker state and flags, counts per turn returns to 8192
// top level: wires mtet_ctrl and mtet_datapath to the stream ports; uses mtet_pkg
`timescale 1ns / 1ps

module multi_turn_encoder_tracker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration: counts per turn
  input  logic                                  cfg_we_i,
  input  logic [mtet_pkg::CPT_BITS-1:0]         cfg_wdata_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [mtet_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,  // raw_position, target_total
  input  logic                                  s_axis_tuser,  // cmd
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [mtet_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,  // total_position,
                                                               // single_turn_angle, turn_count
  output logic [mtet_pkg::OUT_USER_BITS-1:0]    m_axis_tuser   // initialized, saturated
);
  import mtet_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  // unpacked input beat
  logic [POS_BITS-1:0]        in_raw;
  logic signed [TOT_BITS-1:0] in_target;

  // result fields from the output register
  logic signed [TOT_BITS-1:0]  out_total;
  logic [ANGLE_BITS-1:0]       out_angle;
  logic signed [TURN_BITS-1:0] out_turns;
  logic                        out_init;
  logic                        out_sat;

  assign in_raw    = s_axis_tdata[POS_BITS-1:0];
  assign in_target = s_axis_tdata[POS_BITS +: TOT_BITS];

  // one item in flight; a finished result may wait in the output
  // register while the next beat is accepted
  mtet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctrl_cmd),
    .sts_i       (ctrl_sts)
  );

  // turn tracking, total position and modulo by counts per turn
  mtet_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_raw_i    (in_raw),
    .in_target_i (in_target),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts),
    .out_total_o (out_total),
    .out_angle_o (out_angle),
    .out_turns_o (out_turns),
    .out_init_o  (out_init),
    .out_sat_o   (out_sat)
  );

  // pack result beat, lowest field first
  assign m_axis_tdata = {out_turns, out_angle, out_total};
  assign m_axis_tuser = {out_sat, out_init};

endmodule

### rtl/mtet_checker.sv
// port-level checks on the multi-turn encoder tracker
// depends on mtet_pkg and multi_turn_encoder_tracker_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "multi_turn_encoder_tracker_defines.svh"

module mtet_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [mtet_pkg::CPT_BITS-1:0]      cfg_wdata_i,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [mtet_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,   // raw_position, target_total
  input logic                               s_axis_tuser,   // cmd
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [mtet_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,   // total, angle, turn_count
  input logic [mtet_pkg::OUT_USER_BITS-1:0] m_axis_tuser    // initialized, saturated
);
  import mtet_pkg::*;

  // one item at a time: no input beat right after an accepted one
  `MTET_ASSERT(a_single_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

  // the result valid rises only while the sequencer is back in idle
  `MTET_ASSERT(a_result_frees_input, $rose(m_axis_tvalid) |-> s_axis_tready, "result without idle")

  // initialized flag never drops once reported
  `MTET_ASSERT(a_init_sticky, !$fell(m_axis_tuser[0]), "initialized flag dropped")

  // stalled result beat holds its payload
  `MTET_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind multi_turn_encoder_tracker mtet_checker u_mtet_checker (.*);
